// ----- rtl/lsa_pkg.sv -----
package lsa_pkg;

    // Command codes carried on the cmd port.
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_DECAY = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // One slot of the table as it sits in the slot memory.
    typedef struct packed {
        logic [15:0] key;
        logic [31:0] expiry;
        logic [15:0] radius;
        logic [15:0] rate;
    } lsa_entry_t;

    localparam int ENTRY_W = $bits(lsa_entry_t);

endpackage

// ----- rtl/lsa_ram.sv -----
module lsa_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/light_slot_allocator_with_decay_unit.sv -----
// Channel   Direction  Handshake                          Ports
// ------    ---------  ---------------------------------  ---------------------------------------
// command   in         start high and busy low at edge    cmd, light_key, now_ms, elapsed_ms,
//                                                         new_radius, new_rate, new_expiry,
//                                                         read_slot
// result    out        done high for one cycle            slot, slot_key, slot_radius,
//                                                         slot_expiry, slot_live
//
// Scans: a decay tick and an allocate without a key walk the table once, an allocate
// with a key up to twice (for the key, then for an expired slot), all paced by the
// single read port of the slot memory, which the sequencer walks one slot a cycle.
// A read beyond the table and a no-operation item finish in the cycle after acceptance.
// Reset clears all valid bits at once, so every slot reads as zero; there is no clearing pass.
// Results cannot be stalled: each result is shown for exactly one cycle with done high.
module light_slot_allocator_with_decay_unit
    import lsa_pkg::*;
#(
    parameter int LIGHT_SLOTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [15:0] light_key,
    input  logic [31:0] now_ms,
    input  logic [15:0] elapsed_ms,
    input  logic [15:0] new_radius,
    input  logic [15:0] new_rate,
    input  logic [31:0] new_expiry,
    input  logic [4:0]  read_slot,
    output logic        done,
    output logic [4:0]  slot,
    output logic [15:0] slot_key,
    output logic [15:0] slot_radius,
    output logic [31:0] slot_expiry,
    output logic        slot_live
);

    // Index width, counter width (holds LIGHT_SLOTS itself) and a width wide enough
    // both for an index and for the five-bit slot field.
    localparam int IW = $clog2(LIGHT_SLOTS);
    localparam int CW = IW + 1;
    localparam int XW = (IW > 5) ? IW : 5;
    localparam logic [CW-1:0] N_C = CW'(LIGHT_SLOTS);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_KEY    = 3'd1;
    localparam logic [2:0] S_EXP    = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_DECAY  = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;
    localparam logic [2:0] S_RDOUT  = 3'd6;

    // Control state.
    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic                   upd_reg, upd_next;
    logic                   done_reg, done_next;
    logic [LIGHT_SLOTS-1:0] valid_reg;

    // Latched item fields.
    logic [15:0] key_reg, key_next;
    logic [31:0] now_reg, now_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic [15:0] radius_in_reg, radius_in_next;
    logic [15:0] rate_in_reg, rate_in_next;
    logic [31:0] expiry_in_reg, expiry_in_next;

    // Scan and decay datapath.
    logic [IW-1:0] slot_reg, slot_next;
    logic [IW-1:0] pidx_reg, pidx_next;
    logic          vq_reg, vq_next;
    logic [31:0]   prod_reg, prod_next;
    lsa_entry_t    dent_reg, dent_next;
    logic [IW-1:0] didx_reg, didx_next;

    // Result registers.
    logic [4:0]  out_slot_reg, out_slot_next;
    logic [15:0] out_key_reg, out_key_next;
    logic [15:0] out_radius_reg, out_radius_next;
    logic [31:0] out_expiry_reg, out_expiry_next;
    logic        out_live_reg, out_live_next;

    // Memory ports.
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    lsa_entry_t    wr_data;
    logic [IW-1:0] rd_addr;
    lsa_entry_t    rd_data;

    logic          issue;
    lsa_entry_t    ent;
    logic [XW-1:0] rd_ext;
    logic [XW-1:0] slot_ext;
    logic          rd_in_range;
    logic [31:0]   wide;
    logic [31:0]   diff;
    logic [15:0]   decayed;

    lsa_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(LIGHT_SLOTS)
    ) u_slot_ram (
        .clk  (clk),
        .we   (wr_en),
        .waddr(wr_addr),
        .wdata(wr_data),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    // A slot that was never written since reset reads as all zero.
    assign ent = vq_reg ? rd_data : '0;

    // The scan pointer still has slots to fetch.
    assign issue = (cnt_reg < N_C);

    assign rd_ext      = XW'(read_slot);
    assign slot_ext    = XW'(slot_reg);
    assign rd_in_range = ({4'b0, read_slot} < 9'(LIGHT_SLOTS));

    // Decay arithmetic: the radius is widened by eight fraction bits, the product of
    // elapsed time and rate is taken off, and the result saturates at zero.
    assign wide    = {8'b0, dent_reg.radius, 8'b0};
    assign diff    = wide - prod_reg;
    assign decayed = (prod_reg >= wide) ? 16'd0 : diff[23:8];

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        upd_next        = 1'b0;
        done_next       = 1'b0;
        key_next        = key_reg;
        now_next        = now_reg;
        elapsed_next    = elapsed_reg;
        radius_in_next  = radius_in_reg;
        rate_in_next    = rate_in_reg;
        expiry_in_next  = expiry_in_reg;
        slot_next       = slot_reg;
        pidx_next       = pidx_reg;
        prod_next       = prod_reg;
        dent_next       = dent_reg;
        didx_next       = didx_reg;
        out_slot_next   = out_slot_reg;
        out_key_next    = out_key_reg;
        out_radius_next = out_radius_reg;
        out_expiry_next = out_expiry_reg;
        out_live_next   = out_live_reg;
        wr_en           = 1'b0;
        wr_addr         = didx_reg;
        wr_data         = dent_reg;
        rd_addr         = slot_reg;

        // In the scan states the pointer walks the memory one slot a cycle; the entry
        // fetched in the previous cycle is checked while the next one is fetched.
        if ((state_reg == S_KEY) || (state_reg == S_EXP) || (state_reg == S_DECAY))
        begin
            rd_addr   = issue ? cnt_reg[IW-1:0] : '0;
            cnt_next  = cnt_reg + CW'(issue);
            pend_next = issue;
            pidx_next = rd_addr;
        end
        vq_next = valid_reg[rd_addr];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next       = light_key;
                    now_next       = now_ms;
                    elapsed_next   = elapsed_ms;
                    radius_in_next = new_radius;
                    rate_in_next   = new_rate;
                    expiry_in_next = new_expiry;
                    cnt_next       = '0;
                    pend_next      = 1'b0;
                    unique case (cmd)
                        CMD_ALLOC:
                        begin
                            state_next = (light_key != 16'd0) ? S_KEY : S_EXP;
                        end
                        CMD_DECAY:
                        begin
                            state_next = S_DECAY;
                        end
                        CMD_READ:
                        begin
                            out_slot_next = read_slot;
                            if (rd_in_range)
                            begin
                                slot_next  = rd_ext[IW-1:0];
                                state_next = S_RDWAIT;
                            end
                            else
                            begin
                                // A slot beyond the table reports all zero.
                                out_key_next    = '0;
                                out_radius_next = '0;
                                out_expiry_next = '0;
                                out_live_next   = 1'b0;
                                done_next       = 1'b1;
                            end
                        end
                        CMD_NOP:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_KEY:
            begin
                priority if (pend_reg && (ent.key == key_reg))
                begin
                    slot_next  = pidx_reg;
                    state_next = S_WRITE;
                end
                else if (!issue && !pend_reg)
                begin
                    // No slot holds the key: restart the walk for an expired slot.
                    cnt_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_EXP;
                end
            end
            S_EXP:
            begin
                priority if (pend_reg && (ent.expiry < now_reg))
                begin
                    slot_next  = pidx_reg;
                    state_next = S_WRITE;
                end
                else if (!issue && !pend_reg)
                begin
                    // Nothing has expired: fall back to the first slot.
                    slot_next  = '0;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                wr_en           = 1'b1;
                wr_addr         = slot_reg;
                wr_data.key     = key_reg;
                wr_data.expiry  = expiry_in_reg;
                wr_data.radius  = radius_in_reg;
                wr_data.rate    = rate_in_reg;
                out_slot_next   = slot_ext[4:0];
                out_key_next    = key_reg;
                out_radius_next = radius_in_reg;
                out_expiry_next = expiry_in_reg;
                out_live_next   = (expiry_in_reg >= now_reg);
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            S_DECAY:
            begin
                // First stage multiplies, second stage subtracts and writes back.
                upd_next  = pend_reg && (ent.expiry >= now_reg) && (ent.radius != 16'd0);
                prod_next = 32'(elapsed_reg) * 32'(ent.rate);
                dent_next = ent;
                didx_next = pidx_reg;
                wr_en          = upd_reg;
                wr_addr        = didx_reg;
                wr_data        = dent_reg;
                wr_data.radius = decayed;
                if (!issue && !pend_reg && !upd_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RDWAIT:
            begin
                state_next = S_RDOUT;
            end
            S_RDOUT:
            begin
                out_key_next    = ent.key;
                out_radius_next = ent.radius;
                out_expiry_next = ent.expiry;
                out_live_next   = (ent.expiry >= now_reg);
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            upd_reg   <= 1'b0;
            done_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            upd_reg   <= upd_next;
            done_reg  <= done_next;
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        now_reg        <= now_next;
        elapsed_reg    <= elapsed_next;
        radius_in_reg  <= radius_in_next;
        rate_in_reg    <= rate_in_next;
        expiry_in_reg  <= expiry_in_next;
        slot_reg       <= slot_next;
        pidx_reg       <= pidx_next;
        vq_reg         <= vq_next;
        prod_reg       <= prod_next;
        dent_reg       <= dent_next;
        didx_reg       <= didx_next;
        out_slot_reg   <= out_slot_next;
        out_key_reg    <= out_key_next;
        out_radius_reg <= out_radius_next;
        out_expiry_reg <= out_expiry_next;
        out_live_reg   <= out_live_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign slot        = out_slot_reg;
    assign slot_key    = out_key_reg;
    assign slot_radius = out_radius_reg;
    assign slot_expiry = out_expiry_reg;
    assign slot_live   = out_live_reg;

    // A result is only shown once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while the sequencer is still working");

    // Any accepted command other than a no-operation or a read beyond the table
    // makes the block busy in the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd != CMD_NOP) && ((cmd != CMD_READ) || rd_in_range))
        |=> busy)
        else $error("accepted command did not start the sequencer");

    // The slot memory is only written by an allocate or a decay write-back.
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == S_WRITE) || (state_reg == S_DECAY)))
        else $error("slot memory written outside allocate or decay");

    // The scan pointer never runs past the end of the table.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= N_C))
        else $error("scan pointer beyond the table");

endmodule

// ----- sim/light_slot_checker.sv -----
`timescale 1ns / 1ps

// Shadow copy of the slot table, predicting one report per allocate or read command.
module light_slot_checker
    import lsa_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  cmd,
    input  logic [15:0] light_key,
    input  logic [31:0] now_ms,
    input  logic [15:0] elapsed_ms,
    input  logic [15:0] new_radius,
    input  logic [15:0] new_rate,
    input  logic [31:0] new_expiry,
    input  logic [4:0]  read_slot,
    input  logic        done,
    input  logic [4:0]  slot,
    input  logic [15:0] slot_key,
    input  logic [15:0] slot_radius,
    input  logic [31:0] slot_expiry,
    input  logic        slot_live,
    output int          mismatches,
    output int          outstanding,
    output int          reports_checked
);

    typedef struct packed {
        logic [4:0]  slot;
        logic [15:0] key;
        logic [15:0] radius;
        logic [31:0] expiry;
        logic        live;
    } slot_report_t;

    logic [15:0] key_mem    [SLOTS];
    logic [31:0] expiry_mem [SLOTS];
    logic [15:0] radius_mem [SLOTS];
    logic [15:0] rate_mem   [SLOTS];

    slot_report_t pending_reports[$];
    int           err_count;
    int           seen_count;

    function automatic slot_report_t report_of(input int idx, input logic [31:0] now);
        slot_report_t r;
        r.slot = idx[4:0];
        if (idx < SLOTS)
        begin
            r.key    = key_mem[idx];
            r.radius = radius_mem[idx];
            r.expiry = expiry_mem[idx];
            r.live   = (expiry_mem[idx] >= now);
        end
        else
        begin
            r.key    = '0;
            r.radius = '0;
            r.expiry = '0;
            r.live   = 1'b0;
        end
        return r;
    endfunction

    // Key match wins, then the first expired slot, then slot 0.
    function automatic int choose_slot(input logic [15:0] key, input logic [31:0] now);
        int  pick;
        bit  found;
        pick  = 0;
        found = 0;
        if (key != 16'd0)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!found && key_mem[i] == key)
                begin
                    pick  = i;
                    found = 1;
                end
            end
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!found && expiry_mem[i] < now)
            begin
                pick  = i;
                found = 1;
            end
        end
        return pick;
    endfunction

    task automatic decay_table(input logic [15:0] elapsed, input logic [31:0] now);
        logic [63:0] scaled;
        logic [63:0] loss;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (expiry_mem[i] >= now && radius_mem[i] != 16'd0)
            begin
                scaled = {40'd0, radius_mem[i], 8'd0};
                loss   = 64'(elapsed) * 64'(rate_mem[i]);
                scaled = (loss >= scaled) ? 64'd0 : (scaled - loss);
                radius_mem[i] = scaled[23:8];
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int           idx;
        slot_report_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                key_mem[i]    = '0;
                expiry_mem[i] = '0;
                radius_mem[i] = '0;
                rate_mem[i]   = '0;
            end
            pending_reports.delete();
            err_count       = 0;
            seen_count      = 0;
            mismatches      <= 0;
            outstanding     <= 0;
            reports_checked <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_reports.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual slot %0d",
                             $time, slot);
                    err_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("slot", 32'(want.slot), 32'(slot));
                    check_field("slot_key", 32'(want.key), 32'(slot_key));
                    check_field("slot_radius", 32'(want.radius), 32'(slot_radius));
                    check_field("slot_expiry", want.expiry, slot_expiry);
                    check_field("slot_live", 32'(want.live), 32'(slot_live));
                    seen_count++;
                end
            end
            if (start && !busy)
            begin
                case (cmd)
                    CMD_ALLOC:
                    begin
                        idx = choose_slot(light_key, now_ms);
                        key_mem[idx]    = light_key;
                        radius_mem[idx] = new_radius;
                        rate_mem[idx]   = new_rate;
                        expiry_mem[idx] = new_expiry;
                        pending_reports.push_back(report_of(idx, now_ms));
                    end
                    CMD_DECAY:
                        decay_table(elapsed_ms, now_ms);
                    CMD_READ:
                        pending_reports.push_back(report_of(int'(read_slot), now_ms));
                    default:
                        ;
                endcase
            end
            mismatches      <= err_count;
            outstanding     <= pending_reports.size();
            reports_checked <= seen_count;
        end
    end

endmodule

// ----- sim/tb_light_slot_allocator_with_decay_unit.sv -----
`timescale 1ns / 1ps

// Top of the slot allocator bench. It only produces command items and gives the
// verdict; the checker beside the block keeps the shadow table and compares every
// report the block strobes out.
module tb_light_slot_allocator_with_decay_unit;
    import lsa_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [15:0] light_key;
    logic [31:0] now_ms;
    logic [15:0] elapsed_ms;
    logic [15:0] new_radius;
    logic [15:0] new_rate;
    logic [31:0] new_expiry;
    logic [4:0]  read_slot;
    logic        done;
    logic [4:0]  slot;
    logic [15:0] slot_key;
    logic [15:0] slot_radius;
    logic [31:0] slot_expiry;
    logic        slot_live;

    int mismatches;
    int outstanding;
    int reports_checked;

    // Per-command tallies for the closing summary.
    int alloc_count;
    int decay_count;
    int read_count;
    int nop_count;

    // Scene time that advances with every decay tick, so that slots age and expire
    // the way they would frame after frame.
    logic [31:0] scene_ms;

    light_slot_allocator_with_decay_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .light_key   (light_key),
        .now_ms      (now_ms),
        .elapsed_ms  (elapsed_ms),
        .new_radius  (new_radius),
        .new_rate    (new_rate),
        .new_expiry  (new_expiry),
        .read_slot   (read_slot),
        .done        (done),
        .slot        (slot),
        .slot_key    (slot_key),
        .slot_radius (slot_radius),
        .slot_expiry (slot_expiry),
        .slot_live   (slot_live)
    );

    light_slot_checker #(
        .SLOTS(32)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .light_key       (light_key),
        .now_ms          (now_ms),
        .elapsed_ms      (elapsed_ms),
        .new_radius      (new_radius),
        .new_rate        (new_rate),
        .new_expiry      (new_expiry),
        .read_slot       (read_slot),
        .done            (done),
        .slot            (slot),
        .slot_key        (slot_key),
        .slot_radius     (slot_radius),
        .slot_expiry     (slot_expiry),
        .slot_live       (slot_live),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .reports_checked (reports_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop. The slowest legal run is roughly 900 items, well under 2 ms, so 20 ms
    // leaves a wide margin.
    initial
    begin
        #20_000_000;
        $display("Timeout: the block stopped making progress.");
        $display("== FAIL ==");
        $finish;
    end

    // Presents one command item and returns at the edge where it was accepted.
    // The caller either presents the next item right away, which keeps start high
    // with a single assignment, or lowers start through idle_for.
    task automatic issue(input logic [1:0] c, input logic [15:0] key,
                         input logic [31:0] now, input logic [15:0] elapsed,
                         input logic [15:0] radius, input logic [15:0] rate,
                         input logic [31:0] expiry, input logic [4:0] rd);
        start      <= 1'b1;
        cmd        <= c;
        light_key  <= key;
        now_ms     <= now;
        elapsed_ms <= elapsed;
        new_radius <= radius;
        new_rate   <= rate;
        new_expiry <= expiry;
        read_slot  <= rd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        case (c)
            CMD_ALLOC: alloc_count++;
            CMD_DECAY: decay_count++;
            CMD_READ:  read_count++;
            default:   nop_count++;
        endcase
    endtask

    task automatic idle_for(input int cycles);
        start <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    initial
    begin
        int          real_items;
        int          pick;
        bit          calm;
        bit          tail;
        logic [15:0] key;
        logic [15:0] elapsed;
        logic [15:0] rate;
        logic [31:0] expiry;

        rst_n      <= 1'b0;
        start      <= 1'b0;
        cmd        <= CMD_NOP;
        light_key  <= '0;
        now_ms     <= '0;
        elapsed_ms <= '0;
        new_radius <= '0;
        new_rate   <= '0;
        new_expiry <= '0;
        read_slot  <= '0;
        alloc_count = 0;
        decay_count = 0;
        read_count  = 0;
        nop_count   = 0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. After reset every slot is zero, so at time zero all of
        // them count as live and none as expired.
        issue(CMD_READ, 16'h0000, 32'h0, 16'h0000, 16'h0000, 16'h0000, 32'h0, 5'd0);
        issue(CMD_READ, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              32'hFFFF_FFFF, 5'd31);
        // Nothing has expired and no key is given, so the default slot 0 is taken.
        issue(CMD_ALLOC, 16'h0000, 32'h0, 16'h0000, 16'hFFFF, 16'h0001,
              32'hFFFF_FFFF, 5'd0);
        // Slot 1 is the first one whose expiry lies before now.
        issue(CMD_ALLOC, 16'h1234, 32'd1, 16'h0000, 16'h1000, 16'h0100, 32'd1000, 5'd0);
        // The same key again must land on the slot that already holds it.
        issue(CMD_ALLOC, 16'h1234, 32'd5, 16'h0000, 16'h0800, 16'hFFFF, 32'd2000, 5'd0);
        // A slot written with zero radius is left alone by decay.
        issue(CMD_ALLOC, 16'hFFFF, 32'd10, 16'h0000, 16'h0000, 16'h0040, 32'd500, 5'd0);
        // A slot written with an expiry already in the past is dead on arrival.
        issue(CMD_ALLOC, 16'h0001, 32'd10, 16'h0000, 16'h0001, 16'h0000, 32'd9, 5'd0);
        idle_for(3);
        issue(CMD_DECAY, 16'h0000, 32'd10, 16'd4, 16'h0000, 16'h0000, 32'h0, 5'd0);
        // A huge step drives the fast-decaying slot to zero.
        issue(CMD_DECAY, 16'h0000, 32'd10, 16'hFFFF, 16'h0000, 16'h0000, 32'h0, 5'd0);
        issue(CMD_DECAY, 16'h0000, 32'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0, 5'd0);
        issue(CMD_NOP, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              32'hFFFF_FFFF, 5'd31);
        for (int i = 0; i < 4; i++)
            issue(CMD_READ, 16'h0000, 32'd10, 16'h0000, 16'h0000, 16'h0000, 32'h0, 5'(i));
        idle_for(2);
        // At the end of time everything but slot 0 has expired.
        issue(CMD_ALLOC, 16'h0000, 32'hFFFF_FFFF, 16'h0000, 16'h0200, 16'h0010,
              32'd3000, 5'd0);
        issue(CMD_DECAY, 16'h0000, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 16'h0000,
              32'h0, 5'd0);
        issue(CMD_READ, 16'h0000, 32'hFFFF_FFFF, 16'h0000, 16'h0000, 16'h0000,
              32'h0, 5'd0);
        issue(CMD_ALLOC, 16'h00AA, 32'h0, 16'h0000, 16'h4000, 16'h0001, 32'h0, 5'd0);
        issue(CMD_READ, 16'h0000, 32'h0, 16'h0000, 16'h0000, 16'h0000, 32'h0, 5'd2);

        // Random part. Most items behave like a running scene: a small pool of keys
        // so that matches happen, expiries a little ahead of scene time so that
        // slots age out, and short decay steps. A few items are pure noise.
        scene_ms   = 32'($urandom_range(1, 5000));
        real_items = 0;
        calm       = 0;
        while (real_items < 850)
        begin
            tail = (real_items >= 750);
            if (real_items % 40 == 0)
                calm = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                case ($urandom_range(0, 9))
                    0:       key = 16'h0000;
                    1:       key = 16'($urandom);
                    default: key = 16'($urandom_range(1, 12));
                endcase
                if ($urandom_range(0, 9) == 0)
                    expiry = scene_ms - 32'($urandom_range(1, 50));
                else
                    expiry = scene_ms + 32'($urandom_range(0, 300));
                if ($urandom_range(0, 4) < 3)
                    rate = 16'($urandom_range(0, 4096));
                else
                    rate = 16'($urandom);
                issue(CMD_ALLOC, key, scene_ms, 16'($urandom), 16'($urandom), rate,
                      expiry, 5'($urandom));
            end
            else if (pick < 70)
            begin
                if ($urandom_range(0, 19) < 17)
                    elapsed = 16'($urandom_range(0, 40));
                else
                    elapsed = 16'($urandom);
                scene_ms = scene_ms + 32'(elapsed);
                issue(CMD_DECAY, 16'($urandom), scene_ms, elapsed, 16'($urandom),
                      16'($urandom), $urandom, 5'($urandom));
            end
            else if (pick < 92)
            begin
                issue(CMD_READ, 16'($urandom), scene_ms, 16'($urandom), 16'($urandom),
                      16'($urandom), $urandom, 5'($urandom));
            end
            else if (pick < 96)
            begin
                issue(CMD_NOP, 16'($urandom), $urandom, 16'($urandom), 16'($urandom),
                      16'($urandom), $urandom, 5'($urandom));
            end
            else
            begin
                issue(2'($urandom), 16'($urandom), $urandom, 16'($urandom),
                      16'($urandom), 16'($urandom), $urandom, 5'($urandom));
            end
            // The opcode actually accepted decides whether this item counts.
            if (cmd != CMD_NOP)
                real_items++;
            if (!tail && !calm && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 6));
        end
        start <= 1'b0;

        // Drain: wait for the last report, then give a slow decay tick or no-op
        // time to finish before judging.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);

        $display("Covered %0d allocates, %0d decay ticks, %0d reads and %0d no-ops.",
                 alloc_count, decay_count, read_count, nop_count);
        $display("%0d slot reports were compared against the shadow table.",
                 reports_checked);
        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("%0d mismatches found.", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/lsa_pkg.sv
rtl/lsa_ram.sv
rtl/light_slot_allocator_with_decay_unit.sv
sim/light_slot_checker.sv
sim/tb_light_slot_allocator_with_decay_unit.sv
